>>> rtl/core/lrast_pkg.sv
`timescale 1ns / 1ps
// Line rasterizer package: register codes, reset values and shared types.
// No dependencies; used by every module of the block.
package lrast_pkg;

    localparam int CFG_INDEX_W = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_START_X     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_Y     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_X       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_END_Y       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_COLOUR = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_BASE  = 3'd5;

    localparam logic [31:0] BASE_RESET = 32'hC000_0000;
    localparam int          ROW_SHIFT  = 10;

    typedef struct packed {
        logic [8:0]        major_pos;
        logic [8:0]        minor_pos;
        logic [8:0]        major_end;
        logic [8:0]        major_delta;
        logic [8:0]        minor_delta;
        logic signed [10:0] err;
        logic              steep;
        logic              step_down;
    } t_line;

    typedef struct packed {
        logic        pixel_valid;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [31:0] pixel_address;
        logic [15:0] pixel_colour;
        logic        last_pixel;
    } t_pixel;

endpackage

>>> rtl/core/lrast_setup.sv
`timescale 1ns / 1ps
// Line setup: orders the endpoints, picks the major axis and seeds the error term.
// Depends on lrast_pkg.
module lrast_setup (
    input  logic [8:0]       i_start_x,
    input  logic [7:0]       i_start_y,
    input  logic [8:0]       i_end_x,
    input  logic [7:0]       i_end_y,
    output lrast_pkg::t_line o_line
);

    logic [8:0] ax, ay, bx, by;
    logic [8:0] dxa, dya;
    logic       steep;
    logic [8:0] s_amaj, s_amin, s_bmaj, s_bmin;
    logic [8:0] amaj, amin, bmaj, bmin;
    logic [8:0] maj_delta;

    always_comb begin
        ax = i_start_x;
        ay = {1'b0, i_start_y};
        bx = i_end_x;
        by = {1'b0, i_end_y};
        dxa = (bx > ax) ? (bx - ax) : (ax - bx);
        dya = (by > ay) ? (by - ay) : (ay - by);
        steep = dya > dxa;

        s_amaj = steep ? ay : ax;
        s_amin = steep ? ax : ay;
        s_bmaj = steep ? by : bx;
        s_bmin = steep ? bx : by;

        if (s_amaj > s_bmaj) begin
            amaj = s_bmaj;
            amin = s_bmin;
            bmaj = s_amaj;
            bmin = s_amin;
        end else begin
            amaj = s_amaj;
            amin = s_amin;
            bmaj = s_bmaj;
            bmin = s_bmin;
        end

        maj_delta = bmaj - amaj;

        o_line.major_pos   = amaj;
        o_line.minor_pos   = amin;
        o_line.major_end   = bmaj;
        o_line.major_delta = maj_delta;
        o_line.minor_delta = (bmin > amin) ? (bmin - amin) : (amin - bmin);
        o_line.err         = -$signed({3'b000, maj_delta[8:1]});
        o_line.steep       = steep;
        o_line.step_down   = !(amin < bmin);
    end

endmodule

>>> rtl/core/lrast_core.sv
`timescale 1ns / 1ps
// Bresenham stepper: holds the line state, forms one pixel and advances the error term.
// Depends on lrast_pkg; line seed comes from lrast_setup.
module lrast_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_restart,
    input  lrast_pkg::t_line i_seed,
    input  logic [15:0]      i_colour,
    input  logic [31:0]      i_base,
    output lrast_pkg::t_pixel o_pixel
);

    lrast_pkg::t_line r_line, n_line, cur;
    logic             r_active, n_active;
    logic [15:0]      r_colour, colour;
    logic [31:0]      r_base, base;
    logic             active;
    logic             last;
    logic [8:0]       px;
    logic [7:0]       py;
    logic signed [10:0] err_sum;

    always_comb begin
        cur    = i_restart ? i_seed : r_line;
        colour = i_restart ? i_colour : r_colour;
        base   = i_restart ? i_base : r_base;
        active = i_restart || r_active;

        px   = cur.steep ? cur.minor_pos : cur.major_pos;
        py   = cur.steep ? cur.major_pos[7:0] : cur.minor_pos[7:0];
        last = cur.major_pos >= cur.major_end;

        err_sum = cur.err + $signed({2'b00, cur.minor_delta});
        n_line  = cur;
        if (err_sum > 11'sd0) begin
            n_line.minor_pos = cur.step_down ? (cur.minor_pos - 9'd1)
                                             : (cur.minor_pos + 9'd1);
            n_line.err       = err_sum - $signed({2'b00, cur.major_delta});
        end else begin
            n_line.err = err_sum;
        end
        n_line.major_pos = cur.major_pos + 9'd1;
        n_active         = active && !last;

        if (active) begin
            o_pixel.pixel_valid   = 1'b1;
            o_pixel.pixel_x       = px;
            o_pixel.pixel_y       = py;
            o_pixel.pixel_address = base + (32'(py) << lrast_pkg::ROW_SHIFT)
                                         + 32'({px, 1'b0});
            o_pixel.pixel_colour  = colour;
            o_pixel.last_pixel    = last;
        end else begin
            o_pixel = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_advance) begin
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && active) begin
            r_line <= n_line;
        end
        if (i_advance && i_restart) begin
            r_colour <= i_colour;
            r_base   <= i_base;
        end
    end

endmodule

>>> rtl/core/line_rasterizer_top.sv
`timescale 1ns / 1ps
// Line rasterizer top level: configuration registers, input and result registers.
// Depends on lrast_pkg, lrast_setup and lrast_core.
//
//  Channel   Handshake                  Payload
//  input     i_in_valid / o_in_ready    i_restart
//  result    o_out_valid / i_out_ready  o_pixel_valid, o_pixel_x, o_pixel_y,
//                                       o_pixel_address, o_pixel_colour, o_last_pixel
//  config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One transaction per cycle sustained while the result is not stalled; a result passes
// through the input register and then the result register.
// Synchronous active-low reset clears valid and active flags, resets config registers.
// A stalled result holds; the input register still takes a transaction while it is empty.
// Configuration writes are always taken and act at the next restart.
module line_rasterizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_pixel_valid,
    output logic [8:0]  o_pixel_x,
    output logic [7:0]  o_pixel_y,
    output logic [31:0] o_pixel_address,
    output logic [15:0] o_pixel_colour,
    output logic        o_last_pixel,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [lrast_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [8:0]  r_start_x, r_end_x;
    logic [7:0]  r_start_y, r_end_y;
    logic [15:0] r_line_colour;
    logic [31:0] r_frame_base;

    logic r_in_valid, r_in_restart;
    logic r_out_valid;
    logic move;

    lrast_pkg::t_line  seed;
    lrast_pkg::t_pixel pixel, r_pixel;

    assign o_cfg_ready = 1'b1;
    assign move        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x     <= '0;
            r_start_y     <= '0;
            r_end_x       <= '0;
            r_end_y       <= '0;
            r_line_colour <= '0;
            r_frame_base  <= lrast_pkg::BASE_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                lrast_pkg::REG_START_X:     r_start_x     <= i_cfg_data[8:0];
                lrast_pkg::REG_START_Y:     r_start_y     <= i_cfg_data[7:0];
                lrast_pkg::REG_END_X:       r_end_x       <= i_cfg_data[8:0];
                lrast_pkg::REG_END_Y:       r_end_y       <= i_cfg_data[7:0];
                lrast_pkg::REG_LINE_COLOUR: r_line_colour <= i_cfg_data[15:0];
                lrast_pkg::REG_FRAME_BASE:  r_frame_base  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_restart <= i_restart;
        end
        if (move) begin
            r_pixel <= pixel;
        end
    end

    lrast_setup u_setup (
        .i_start_x (r_start_x),
        .i_start_y (r_start_y),
        .i_end_x   (r_end_x),
        .i_end_y   (r_end_y),
        .o_line    (seed)
    );

    lrast_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (move),
        .i_restart (r_in_restart),
        .i_seed    (seed),
        .i_colour  (r_line_colour),
        .i_base    (r_frame_base),
        .o_pixel   (pixel)
    );

    assign o_out_valid     = r_out_valid;
    assign o_pixel_valid   = r_pixel.pixel_valid;
    assign o_pixel_x       = r_pixel.pixel_x;
    assign o_pixel_y       = r_pixel.pixel_y;
    assign o_pixel_address = r_pixel.pixel_address;
    assign o_pixel_colour  = r_pixel.pixel_colour;
    assign o_last_pixel    = r_pixel.last_pixel;

    a_idle_result_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_pixel_valid |->
            (o_pixel_x == 9'd0) && (o_pixel_y == 8'd0) && (o_pixel_address == 32'd0)
            && (o_pixel_colour == 16'd0) && !o_last_pixel)
        else $error("idle result carries non-zero fields");

    a_last_is_pixel : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last_pixel |-> o_pixel_valid)
        else $error("last marker on a result without a pixel");

    a_restart_draws : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move && r_in_restart |=> o_out_valid && o_pixel_valid)
        else $error("restart transaction gave no pixel");

    a_stall_holds_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !move |=> r_in_valid && $stable(r_in_restart))
        else $error("pending input transaction lost while stalled");

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for line_rasterizer_top: Bresenham pixel prediction and compare.
// Depends on lrast_pkg and the line_rasterizer_top RTL only.

class bresenham_pixel_board;
    logic [8:0]  start_x, end_x;
    logic [7:0]  start_y, end_y;
    logic [15:0] line_colour;
    logic [31:0] frame_base;

    logic [9:0]         major_pos;
    logic [8:0]         minor_pos, major_end, major_delta, minor_delta;
    logic signed [10:0] err_acc;
    bit                 steep, step_down, drawing;
    logic [15:0]        held_colour;
    logic [31:0]        held_base;

    lrast_pkg::t_pixel pending_pixels[$];
    int     errors, lines, pixels_checked, blanks_checked;

    function new();
        start_x = '0; start_y = '0; end_x = '0; end_y = '0;
        line_colour = '0;
        frame_base = lrast_pkg::BASE_RESET;
        major_pos = '0; minor_pos = '0; major_end = '0;
        major_delta = '0; minor_delta = '0; err_acc = '0;
        steep = 0; step_down = 0; drawing = 0;
        held_colour = '0; held_base = '0;
        errors = 0; lines = 0; pixels_checked = 0; blanks_checked = 0;
    endfunction

    task report(string msg);
        errors++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    function void write_register(logic [lrast_pkg::CFG_INDEX_W-1:0] index,
                                 logic [31:0] data);
        case (index)
            lrast_pkg::REG_START_X:     start_x = data[8:0];
            lrast_pkg::REG_START_Y:     start_y = data[7:0];
            lrast_pkg::REG_END_X:       end_x = data[8:0];
            lrast_pkg::REG_END_Y:       end_y = data[7:0];
            lrast_pkg::REG_LINE_COLOUR: line_colour = data[15:0];
            lrast_pkg::REG_FRAME_BASE:  frame_base = data;
            default: ;
        endcase
    endfunction

    function void load_line();
        int ax, ay, bx, by, dxa, dya, t;
        ax = int'(start_x); ay = int'(start_y); bx = int'(end_x); by = int'(end_y);
        dxa = (bx > ax) ? bx - ax : ax - bx;
        dya = (by > ay) ? by - ay : ay - by;
        steep = dya > dxa;
        if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
        end
        if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
        end
        major_pos = 10'(ax);
        minor_pos = 9'(ay);
        major_end = 9'(bx);
        major_delta = 9'(bx - ax);
        minor_delta = 9'((by > ay) ? by - ay : ay - by);
        step_down = !(ay < by);
        err_acc = 11'(-((bx - ax) / 2));
        held_colour = line_colour;
        held_base = frame_base;
        drawing = 1;
    endfunction

    function void accept_item(bit restart);
        lrast_pkg::t_pixel px;
        int     e;
        if (restart) begin
            load_line();
            lines++;
        end
        px = '0;
        if (drawing) begin
            px.pixel_valid = 1'b1;
            px.pixel_x = steep ? minor_pos : major_pos[8:0];
            px.pixel_y = steep ? major_pos[7:0] : minor_pos[7:0];
            px.pixel_address = held_base + ({24'd0, px.pixel_y} << lrast_pkg::ROW_SHIFT)
                             + ({23'd0, px.pixel_x} << 1);
            px.pixel_colour = held_colour;
            px.last_pixel = major_pos >= {1'b0, major_end};
            e = int'(err_acc);
            e = e + int'(minor_delta);
            if (e > 0) begin
                minor_pos = step_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
                e = e - int'(major_delta);
            end
            err_acc = 11'(e);
            major_pos = major_pos + 1'b1;
            if (px.last_pixel)
                drawing = 0;
        end
        pending_pixels.push_back(px);
    endfunction

    task compare_field(string name, int unsigned n, logic [31:0] got,
                       logic [31:0] want);
        if (got !== want)
            report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", n, name, got, want));
    endtask

    task match_pixel(lrast_pkg::t_pixel got);
        lrast_pkg::t_pixel want;
        int unsigned n;
        if (pending_pixels.size() == 0) begin
            report("result transaction with no pixel outstanding");
            return;
        end
        want = pending_pixels.pop_front();
        n = pixels_checked + blanks_checked;
        compare_field("pixel_valid", n, 32'(got.pixel_valid), 32'(want.pixel_valid));
        compare_field("pixel_x", n, 32'(got.pixel_x), 32'(want.pixel_x));
        compare_field("pixel_y", n, 32'(got.pixel_y), 32'(want.pixel_y));
        compare_field("pixel_address", n, got.pixel_address, want.pixel_address);
        compare_field("pixel_colour", n, 32'(got.pixel_colour), 32'(want.pixel_colour));
        compare_field("last_pixel", n, 32'(got.last_pixel), 32'(want.last_pixel));
        if (want.pixel_valid)
            pixels_checked++;
        else
            blanks_checked++;
    endtask
endclass

module testbench;
    localparam logic [lrast_pkg::CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [lrast_pkg::CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int ITEM_TARGET = 1900;
    localparam int CALM_FROM   = 1600;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_restart = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b1;
    logic        o_pixel_valid;
    logic [8:0]  o_pixel_x;
    logic [7:0]  o_pixel_y;
    logic [31:0] o_pixel_address;
    logic [15:0] o_pixel_colour;
    logic        o_last_pixel;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [lrast_pkg::CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    bresenham_pixel_board board = new();
    int items_sent = 0;
    int cfg_writes = 0;
    int phases = 0;
    bit quiet = 0;
    int stall_left = 0;

    line_rasterizer_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_restart      (i_restart),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_pixel_valid  (o_pixel_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_address(o_pixel_address),
        .o_pixel_colour (o_pixel_colour),
        .o_last_pixel   (o_last_pixel),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= (stall_left == 0);
        end else if (items_sent < CALM_FROM && !quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 12);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        lrast_pkg::t_pixel got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.pixel_valid   = o_pixel_valid;
            got.pixel_x       = o_pixel_x;
            got.pixel_y       = o_pixel_y;
            got.pixel_address = o_pixel_address;
            got.pixel_colour  = o_pixel_colour;
            got.last_pixel    = o_last_pixel;
            board.match_pixel(got);
        end
    end

    task automatic send_item(input bit restart);
        int gap;
        if (items_sent < CALM_FROM && !quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 12);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_restart <= restart;
        do @(posedge i_clk); while (!o_in_ready);
        board.accept_item(restart);
        items_sent++;
    endtask

    task automatic cfg_write(input logic [lrast_pkg::CFG_INDEX_W-1:0] index,
                             input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_register(index, data);
        cfg_writes++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        i_cfg_valid <= 1'b0;
        while (board.pending_pixels.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        phases++;
    endtask

    task automatic draw_whole_line(input int extra);
        send_item(1'b1);
        while (board.drawing)
            send_item(1'b0);
        repeat (extra) send_item(1'b0);
    endtask

    function automatic int clamp(input int v, input int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    task automatic random_setup();
        int sx, sy, ex, ey, span, pick;
        pick = $urandom_range(0, 19);
        sx = $urandom_range(0, 511);
        sy = $urandom_range(0, 255);
        if (pick == 0) begin
            sx = $urandom_range(0, 1) ? 511 : 0;
            sy = $urandom_range(0, 1) ? 255 : 0;
            ex = 511 - sx;
            ey = $urandom_range(0, 1) ? 255 - sy : sy;
        end else if (pick == 1) begin
            ex = $urandom_range(0, 511);
            ey = $urandom_range(0, 255);
        end else begin
            span = (pick < 5) ? 63 : 15;
            ex = clamp(sx + $urandom_range(0, 2 * span) - span, 511);
            ey = clamp(sy + $urandom_range(0, 2 * span) - span, 255);
        end
        if ($urandom_range(0, 3) != 0)
            cfg_write(lrast_pkg::REG_START_X, ($urandom << 9) | sx);
        if ($urandom_range(0, 3) != 0)
            cfg_write(lrast_pkg::REG_START_Y, ($urandom << 8) | sy);
        if ($urandom_range(0, 3) != 0)
            cfg_write(lrast_pkg::REG_END_X, ($urandom << 9) | ex);
        if ($urandom_range(0, 3) != 0)
            cfg_write(lrast_pkg::REG_END_Y, ($urandom << 8) | ey);
        if ($urandom_range(0, 2) == 0)
            cfg_write(lrast_pkg::REG_LINE_COLOUR, $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 32'hFFFF : 32'h0) : $urandom);
        if ($urandom_range(0, 2) == 0)
            cfg_write(lrast_pkg::REG_FRAME_BASE, $urandom_range(0, 3) == 0 ?
                      ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0) : $urandom);
        if ($urandom_range(0, 9) == 0)
            cfg_write($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_items();
        int n;
        if ($urandom_range(0, 9) < 7) begin
            draw_whole_line($urandom_range(0, 2));
        end else begin
            n = $urandom_range(1, 40);
            repeat (n) send_item($urandom_range(0, 7) == 0);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // blank before any line, single-pixel line from reset values, blank after it
        send_item(1'b0);
        send_item(1'b1);
        send_item(1'b0);
        drain();

        cfg_write(lrast_pkg::REG_START_X, 32'd3);
        cfg_write(lrast_pkg::REG_START_Y, 32'd2);
        cfg_write(lrast_pkg::REG_END_X, 32'd10);
        cfg_write(lrast_pkg::REG_END_Y, 32'd5);
        cfg_write(lrast_pkg::REG_LINE_COLOUR, 32'hFFFF);
        cfg_write(lrast_pkg::REG_FRAME_BASE, 32'hFFFF_FFFF);
        i_cfg_valid <= 1'b0;
        send_item(1'b1);
        repeat (3) send_item(1'b0);
        draw_whole_line(1);
        drain();

        // steep, reversed, minor axis stepping down at the far corner
        cfg_write(lrast_pkg::REG_START_X, 32'hFFFF_FFFF);
        cfg_write(lrast_pkg::REG_START_X, 32'd509);
        cfg_write(lrast_pkg::REG_START_Y, 32'hFFFF_FFFF);
        cfg_write(lrast_pkg::REG_END_X, 32'd511);
        cfg_write(lrast_pkg::REG_END_Y, 32'd249);
        cfg_write(lrast_pkg::REG_LINE_COLOUR, 32'h0);
        cfg_write(lrast_pkg::REG_FRAME_BASE, 32'h0);
        cfg_write(REG_SPARE_LO, $urandom);
        cfg_write(REG_SPARE_HI, $urandom);
        i_cfg_valid <= 1'b0;
        draw_whole_line(1);
        drain();

        while (items_sent < ITEM_TARGET) begin
            quiet = ($urandom_range(0, 3) == 0);
            random_setup();
            random_items();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (board.pending_pixels.size() != 0)
            board.report($sformatf("%0d pixels never delivered", board.pending_pixels.size()));
        $display("Covered %0d input transactions over %0d phases, %0d register writes.",
                 items_sent, phases, cfg_writes);
        $display("Started %0d lines; checked %0d pixels and %0d blank results, %0d errors.",
                 board.lines, board.pixels_checked, board.blanks_checked, board.errors);
        if (board.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
